@@ hw/rtl/adsr_pkg.sv @@
// ----------------------------------------------------------------------------
// ADSR envelope package
// Shared widths, phase and operation codes, and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package adsr_pkg;

  localparam int TIME_BITS       = 48;
  localparam int LEVEL_FRAC_BITS = 23;
  localparam int LEVEL_BITS      = LEVEL_FRAC_BITS + 1;
  localparam int PHASE_BITS      = 3;
  localparam int OP_BITS         = 2;
  localparam int CFG_ADDR_BITS   = 3;
  localparam int MASK_BITS       = 3;

  // 1.0 in Q1.LEVEL_FRAC_BITS
  localparam logic [LEVEL_BITS-1:0] LEVEL_ONE = {1'b1, {LEVEL_FRAC_BITS{1'b0}}};

  typedef enum logic [PHASE_BITS-1:0] {
    PH_IDLE    = 3'd0,
    PH_ATTACK  = 3'd1,
    PH_DECAY   = 3'd2,
    PH_SUSTAIN = 3'd3,
    PH_RELEASE = 3'd4
  } phase_t;

  typedef enum logic [OP_BITS-1:0] {
    OP_TICK    = 2'd0,
    OP_START   = 2'd1,
    OP_RELEASE = 2'd2
  } op_t;

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    CFG_SUSTAIN = 3'd0,
    CFG_ATTACK  = 3'd1,
    CFG_DECAY   = 3'd2,
    CFG_RELEASE = 3'd3,
    CFG_INSTANT = 3'd4
  } cfg_idx_t;

  // instant_mask bit positions
  localparam int INST_ATTACK  = 0;
  localparam int INST_DECAY   = 1;
  localparam int INST_RELEASE = 2;

  localparam logic [MASK_BITS-1:0] INSTANT_RESET = '1;

endpackage : adsr_pkg

`default_nettype wire

@@ hw/rtl/adsr_envelope_generator.sv @@
// ----------------------------------------------------------------------------
// Linear ADSR envelope generator
// Attack/decay/sustain/release envelope in Q1.23 with scheduled start and
// release times; one result per tick.
// ----------------------------------------------------------------------------
// Usage: the block takes one transfer per clock on the input channel. A tick
// (operation 0) carries the current sample time and yields one result, the
// envelope level and phase after that tick, registered in the cycle after the
// transfer. Note start (1) and release (2) carry a trigger time, update the
// scheduled times and give no result; operation 3 is dropped. The envelope
// state is updated in the cycle of the transfer by one add/compare/clamp on
// the level and two 48-bit time compares, so a tick can follow a tick in every
// cycle. in_stall is raised only while the output register holds a result that
// the receiver is stalling. A stored time of 0 means nothing is scheduled.
// Step sizes and the sustain level must be written through the cfg port while
// the block is idle, not enforced by it; sustain above 1.0 is treated as 1.0.
// ----------------------------------------------------------------------------
`default_nettype none

module adsr_envelope_generator (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  // configuration write port
  input  wire logic                                  cfg_we,
  input  wire logic [adsr_pkg::CFG_ADDR_BITS-1:0]    cfg_addr,
  input  wire logic [adsr_pkg::LEVEL_BITS-1:0]       cfg_wdata,
  // input channel
  input  wire logic                                  in_valid,
  output      logic                                  in_stall,
  input  wire logic [adsr_pkg::OP_BITS-1:0]          in_operation,
  input  wire logic [adsr_pkg::TIME_BITS-1:0]        in_event_time,
  // result channel
  output      logic                                  out_valid,
  input  wire logic                                  out_stall,
  output      logic [adsr_pkg::LEVEL_BITS-1:0]       out_level,
  output      logic [adsr_pkg::PHASE_BITS-1:0]       out_phase
);

  import adsr_pkg::*;

  // signed working width: level plus a step never overflows, difference
  // never underflows
  localparam int WORK_BITS = LEVEL_BITS + 2;

  // -------------------------------------------------------------------------
  // Configuration registers
  // -------------------------------------------------------------------------
  logic [LEVEL_BITS-1:0] sustain_r;
  logic [LEVEL_BITS-1:0] attack_step_r;
  logic [LEVEL_BITS-1:0] decay_step_r;
  logic [LEVEL_BITS-1:0] release_step_r;
  logic [MASK_BITS-1:0]  instant_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sustain_r      <= '0;
      attack_step_r  <= '0;
      decay_step_r   <= '0;
      release_step_r <= '0;
      instant_r      <= INSTANT_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_SUSTAIN: sustain_r      <= cfg_wdata;
        CFG_ATTACK:  attack_step_r  <= cfg_wdata;
        CFG_DECAY:   decay_step_r   <= cfg_wdata;
        CFG_RELEASE: release_step_r <= cfg_wdata;
        CFG_INSTANT: instant_r      <= cfg_wdata[MASK_BITS-1:0];
        default:     ; // out-of-range index: write dropped
      endcase
    end
  end

  // sustain saturates at 1.0
  logic [LEVEL_BITS-1:0] sus_lvl;
  assign sus_lvl = (sustain_r > LEVEL_ONE) ? LEVEL_ONE : sustain_r;

  // -------------------------------------------------------------------------
  // Envelope state
  // -------------------------------------------------------------------------
  phase_t                phase_r,  phase_nxt;
  logic [LEVEL_BITS-1:0] level_r,  level_nxt;
  logic [TIME_BITS-1:0]  pstart_r, pstart_nxt;
  logic [TIME_BITS-1:0]  prel_r,   prel_nxt;

  logic in_xfer;
  logic tick_xfer;
  logic out_xfer;

  assign in_xfer   = in_valid && !in_stall;
  assign tick_xfer = in_xfer && (in_operation == OP_TICK);
  assign out_xfer  = out_valid && !out_stall;

  // input side stalls only behind a held result
  assign in_stall  = out_valid && out_stall;

  // next-state logic
  always_comb begin
    logic signed [WORK_BITS-1:0] lvl_w;
    logic signed [WORK_BITS-1:0] one_w;
    logic signed [WORK_BITS-1:0] sus_w;
    logic signed [WORK_BITS-1:0] up_w;
    logic signed [WORK_BITS-1:0] dn_dec_w;
    logic signed [WORK_BITS-1:0] dn_rel_w;
    logic                        start_fire;
    phase_t                      ph;

    phase_nxt  = phase_r;
    level_nxt  = level_r;
    pstart_nxt = pstart_r;
    prel_nxt   = prel_r;

    one_w      = signed'({2'b00, LEVEL_ONE});
    sus_w      = signed'({2'b00, sus_lvl});
    start_fire = (pstart_r != '0) && (in_event_time > pstart_r);

    // a fired start restarts from zero in attack
    ph    = start_fire ? PH_ATTACK : phase_r;
    lvl_w = start_fire ? '0 : signed'({2'b00, level_r});

    up_w     = lvl_w + signed'({2'b00, attack_step_r});
    dn_dec_w = lvl_w - signed'({2'b00, decay_step_r});
    dn_rel_w = lvl_w - signed'({2'b00, release_step_r});

    if (in_xfer) begin
      case (in_operation)
        OP_START: begin
          pstart_nxt = in_event_time;
          prel_nxt   = '0;
        end
        OP_RELEASE: begin
          prel_nxt   = in_event_time;
          pstart_nxt = '0;
          phase_nxt  = PH_SUSTAIN;
        end
        OP_TICK: begin
          if (start_fire) begin
            pstart_nxt = '0;
          end
          case (ph)
            PH_ATTACK: begin
              if (instant_r[INST_ATTACK] || (up_w > one_w)) begin
                lvl_w = one_w;
                ph    = PH_DECAY;
              end else begin
                lvl_w = up_w;
              end
            end
            PH_DECAY: begin
              if (instant_r[INST_DECAY] || (dn_dec_w < sus_w)) begin
                lvl_w = sus_w;
                ph    = PH_SUSTAIN;
              end else begin
                lvl_w = dn_dec_w;
              end
            end
            PH_SUSTAIN: begin
              if (sus_lvl != '0) begin
                if ((prel_r != '0) && (in_event_time > prel_r)) begin
                  ph       = PH_RELEASE;
                  prel_nxt = '0;
                end
              end else begin
                // zero sustain drops straight into release
                ph = PH_RELEASE;
              end
            end
            PH_RELEASE: begin
              if (instant_r[INST_RELEASE] || (dn_rel_w < 0)) begin
                lvl_w = '0;
                ph    = PH_IDLE;
              end else begin
                lvl_w = dn_rel_w;
              end
            end
            default: ph = PH_IDLE;
          endcase
          phase_nxt = ph;
          level_nxt = lvl_w[LEVEL_BITS-1:0];
        end
        default: ; // unused operation code: no effect
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      level_r  <= '0;
      pstart_r <= '0;
      prel_r   <= '0;
    end else begin
      phase_r  <= phase_nxt;
      level_r  <= level_nxt;
      pstart_r <= pstart_nxt;
      prel_r   <= prel_nxt;
    end
  end

  // -------------------------------------------------------------------------
  // Result register
  // -------------------------------------------------------------------------
  logic                  out_valid_r, out_valid_nxt;
  logic [LEVEL_BITS-1:0] out_level_r, out_level_nxt;
  phase_t                out_phase_r, out_phase_nxt;

  // output logic
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_level_nxt = out_level_r;
    out_phase_nxt = out_phase_r;
    if (tick_xfer) begin
      out_valid_nxt = 1'b1;
      out_level_nxt = level_nxt;
      out_phase_nxt = phase_nxt;
    end else if (out_xfer) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_level_r <= out_level_nxt;
    out_phase_r <= out_phase_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_level = out_level_r;
  assign out_phase = out_phase_r;

endmodule : adsr_envelope_generator

`default_nettype wire

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// ADSR envelope generator testbench
// Drives ticks, note starts and releases into the envelope generator and
// checks every level/phase result against an in-bench envelope tracker, over
// several register settings and three mixes of sender and receiver idling.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import adsr_pkg::*;

  // operation code 3 is not defined; the block drops it
  localparam logic [OP_BITS-1:0]    OP_UNUSED       = 2'd3;
  localparam logic [TIME_BITS-1:0]  TIME_MAX        = '1;
  localparam longint                FULL_SCALE      = longint'(LEVEL_ONE);
  localparam int                    SETTLE_CYCLES   = 4;     // output register is 1 deep
  localparam int                    HOLD_LEN        = 400;   // long receiver hold-off
  localparam int                    WATCHDOG_LIMIT  = 2000;  // several times HOLD_LEN
  localparam int                    BURSTS_PER_MODE = 4;
  localparam int                    BURST_ITEMS     = 110;

  typedef struct packed {
    logic [OP_BITS-1:0]   op;
    logic [TIME_BITS-1:0] stamp;
  } env_event_t;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] level;
    phase_t                phase;
  } env_result_t;

  logic                     clk           = 1'b0;
  logic                     rst_n         = 1'b0;
  logic                     cfg_we        = 1'b0;
  logic [CFG_ADDR_BITS-1:0] cfg_addr      = '0;
  logic [LEVEL_BITS-1:0]    cfg_wdata     = '0;
  logic                     in_valid      = 1'b0;
  logic                     in_stall;
  logic [OP_BITS-1:0]       in_operation  = '0;
  logic [TIME_BITS-1:0]     in_event_time = '0;
  logic                     out_valid;
  logic                     out_stall     = 1'b0;
  logic [LEVEL_BITS-1:0]    out_level;
  logic [PHASE_BITS-1:0]    out_phase;

  adsr_envelope_generator dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_event_time(in_event_time),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_level    (out_level),
    .out_phase    (out_phase)
  );

  always #5 clk = ~clk;

  // events waiting to be offered, and levels the block still owes us
  env_event_t  env_events[$];
  env_result_t levels_due[$];

  // envelope tracker: register copies and envelope state
  longint               sustain_cfg, attack_cfg, decay_cfg, release_cfg;
  logic [MASK_BITS-1:0] instant_cfg;
  phase_t               track_phase;
  longint               track_level;
  logic [TIME_BITS-1:0] start_at, release_at;

  // idling knobs, in percent of cycles; hold_cycles forces a long out_stall
  int send_idle_pct = 19;
  int recv_idle_pct = 78;
  int hold_cycles   = 0;

  int                   errors         = 0;
  int                   items_queued   = 0;
  int                   levels_checked = 0;
  int                   settings_used  = 1;  // reset values count as one
  int                   quiet_cycles   = 0;
  logic [TIME_BITS-1:0] clock_now      = '0;

  // --------------------------------------------------------------------------
  // Envelope tracker: applies one accepted transfer to the local state and
  // queues the level/phase the block must return for a tick.
  // --------------------------------------------------------------------------
  task automatic track_envelope(input logic [OP_BITS-1:0] op,
                                input logic [TIME_BITS-1:0] now);
    longint      sus;
    env_result_t res;
    // sustain above 1.0 saturates
    sus = (sustain_cfg > FULL_SCALE) ? FULL_SCALE : sustain_cfg;
    case (op)
      OP_START: begin
        start_at   = now;
        release_at = '0;
      end
      OP_RELEASE: begin
        // release drops any pending start and parks in sustain at the current level
        release_at  = now;
        start_at    = '0;
        track_phase = PH_SUSTAIN;
      end
      OP_TICK: begin
        // a start time of 0 never fires; otherwise it fires strictly after its time
        if (start_at != 0 && now > start_at) begin
          track_level = 0;
          track_phase = PH_ATTACK;
          start_at    = '0;
        end
        case (track_phase)
          PH_ATTACK: begin
            if (instant_cfg[INST_ATTACK]) begin
              track_level = FULL_SCALE;
              track_phase = PH_DECAY;
            end else begin
              track_level = track_level + attack_cfg;
              // exactly 1.0 stays in attack
              if (track_level > FULL_SCALE) begin
                track_level = FULL_SCALE;
                track_phase = PH_DECAY;
              end
            end
          end
          PH_DECAY: begin
            if (instant_cfg[INST_DECAY]) begin
              track_level = sus;
              track_phase = PH_SUSTAIN;
            end else begin
              track_level = track_level - decay_cfg;
              if (track_level < sus) begin
                track_level = sus;
                track_phase = PH_SUSTAIN;
              end
            end
          end
          PH_SUSTAIN: begin
            if (sus == 0) begin
              track_phase = PH_RELEASE;
            end else if (release_at != 0 && now > release_at) begin
              track_phase = PH_RELEASE;
              release_at  = '0;
            end
          end
          PH_RELEASE: begin
            if (instant_cfg[INST_RELEASE]) begin
              track_level = 0;
              track_phase = PH_IDLE;
            end else begin
              track_level = track_level - release_cfg;
              if (track_level < 0) begin
                track_level = 0;
                track_phase = PH_IDLE;
              end
            end
          end
          default: track_phase = PH_IDLE;
        endcase
        res.level = track_level[LEVEL_BITS-1:0];
        res.phase = track_phase;
        levels_due.push_back(res);
      end
      default: ;  // undefined operation: no effect, no result
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Input driver: holds a stalled payload, otherwise offers the next queued
  // event unless this cycle is picked as a sender gap.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : event_driver
    env_event_t ev;
    if (!rst_n) begin
      in_valid    <= 1'b0;
      track_phase = PH_IDLE;
      track_level = 0;
      start_at    = '0;
      release_at  = '0;
      sustain_cfg = 0;
      attack_cfg  = 0;
      decay_cfg   = 0;
      release_cfg = 0;
      instant_cfg = INSTANT_RESET;
    end else begin
      if (in_valid && !in_stall)
        track_envelope(in_operation, in_event_time);
      if (!in_valid || !in_stall) begin
        if (env_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          ev = env_events.pop_front();
          in_valid      <= 1'b1;
          in_operation  <= ev.op;
          in_event_time <= ev.stamp;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure: a requested hold-off wins over random stalls.
  always @(posedge clk) begin : result_stall
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_cycles != 0) begin
      out_stall   <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: compares each result transfer with the oldest owed level,
  // and runs the watchdog on cycles without any transfer.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    env_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      levels_checked++;
      if (levels_due.size() == 0) begin
        $display("%0t: unexpected result level %h phase %0d, none owed",
                 $time, out_level, out_phase);
        errors++;
      end else begin
        want = levels_due.pop_front();
        if (out_level !== want.level) begin
          $display("%0t: level mismatch, expected %h got %h", $time, want.level, out_level);
          errors++;
        end
        if (out_phase !== want.phase) begin
          $display("%0t: phase mismatch, expected %0d got %0d", $time, want.phase, out_phase);
          errors++;
        end
      end
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("[adsr_envelope_generator] ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_item(input logic [OP_BITS-1:0] op, input logic [TIME_BITS-1:0] t);
    env_event_t ev;
    ev.op    = op;
    ev.stamp = t;
    env_events.push_back(ev);
    if (op != OP_UNUSED)
      items_queued++;
  endtask

  // Register write, tracker copy updated alongside. Only called while idle.
  task automatic cfg_write(input logic [CFG_ADDR_BITS-1:0] idx,
                           input logic [LEVEL_BITS-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_SUSTAIN: sustain_cfg = val;
      CFG_ATTACK:  attack_cfg  = val;
      CFG_DECAY:   decay_cfg   = val;
      CFG_RELEASE: release_cfg = val;
      CFG_INSTANT: instant_cfg = val[MASK_BITS-1:0];
      default: ;  // out-of-range index is dropped
    endcase
  endtask

  function automatic logic [LEVEL_BITS-1:0] pick_sustain();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return LEVEL_ONE;
      2:       return '1;          // above 1.0, saturates
      default: return LEVEL_BITS'($urandom_range(1, FULL_SCALE));
    endcase
  endfunction

  function automatic logic [LEVEL_BITS-1:0] pick_step();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return LEVEL_ONE;
      2:       return '1;
      3:       return LEVEL_BITS'(1);
      default: return LEVEL_BITS'($urandom_range(FULL_SCALE / 48, FULL_SCALE / 3));
    endcase
  endfunction

  task automatic shuffle_settings();
    logic [LEVEL_BITS-1:0] mask_word;
    mask_word = LEVEL_BITS'($urandom);
    // stages mostly run step by step; upper data bits are don't-care
    if ($urandom_range(1) == 0)
      mask_word[MASK_BITS-1:0] = '0;
    cfg_write(CFG_SUSTAIN, pick_sustain());
    cfg_write(CFG_ATTACK, pick_step());
    cfg_write(CFG_DECAY, pick_step());
    cfg_write(CFG_RELEASE, pick_step());
    cfg_write(CFG_INSTANT, mask_word);
    cfg_write(CFG_ADDR_BITS'(CFG_INSTANT + $urandom_range(1, 3)), LEVEL_BITS'($urandom));
    settings_used++;
  endtask

  // One note: start, a run of ticks, release, another run of ticks.
  task automatic queue_note();
    queue_item(OP_START, clock_now + $urandom_range(0, 3));
    repeat ($urandom_range(2, 40)) begin
      clock_now = clock_now + $urandom_range(0, 2);
      queue_item(OP_TICK, clock_now);
    end
    queue_item(OP_RELEASE, clock_now + $urandom_range(0, 4));
    repeat ($urandom_range(2, 40)) begin
      clock_now = clock_now + $urandom_range(0, 2);
      queue_item(OP_TICK, clock_now);
    end
  endtask

  // Stray events: any operation, times around now, zero, max or anywhere.
  task automatic queue_noise();
    logic [OP_BITS-1:0]   op;
    logic [TIME_BITS-1:0] t;
    repeat ($urandom_range(1, 4)) begin
      op = OP_BITS'($urandom_range(0, 3));
      case ($urandom_range(0, 3))
        0:       t = TIME_BITS'({$urandom, $urandom});
        1:       t = clock_now + $urandom_range(0, 8) - 4;
        2:       t = '0;
        default: t = TIME_MAX;
      endcase
      queue_item(op, t);
    end
  endtask

  task automatic fill_burst(input int target);
    int first;
    first = items_queued;
    // some bursts run up against the top of the time range and wrap
    if ($urandom_range(3) == 0)
      clock_now = TIME_MAX - $urandom_range(0, 300);
    else
      clock_now = TIME_BITS'($urandom_range(0, 5000));
    while (items_queued - first < target) begin
      if ($urandom_range(99) < 75)
        queue_note();
      else
        queue_noise();
    end
  endtask

  // Idle = nothing queued or offered and nothing owed; then let a start or
  // release transfer that gives no result finish inside the block.
  task automatic wait_drained();
    do @(negedge clk);
    while (env_events.size() != 0 || in_valid || levels_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : sequence_main
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings, all stages instant, sustain 0: stray op, start at 0,
    // start firing strictly after its time, sustain 0 falling into release.
    queue_item(OP_TICK, '0);
    queue_item(OP_UNUSED, TIME_MAX);
    queue_item(OP_START, '0);
    queue_item(OP_TICK, 7);
    queue_item(OP_START, 9);
    queue_item(OP_TICK, 9);
    queue_item(OP_TICK, 10);
    queue_item(OP_TICK, 11);
    queue_item(OP_TICK, 12);
    queue_item(OP_TICK, 13);
    wait_drained();

    // Extremes: saturated sustain, attack of exactly 1.0 (holds at 1.0 once),
    // zero decay, full-range release; start at the top of the time range.
    cfg_write(CFG_SUSTAIN, '1);
    cfg_write(CFG_ATTACK, LEVEL_ONE);
    cfg_write(CFG_DECAY, '0);
    cfg_write(CFG_RELEASE, '1);
    cfg_write(CFG_INSTANT, '0);
    cfg_write(CFG_ADDR_BITS'(CFG_INSTANT + 3), '1);
    settings_used++;
    queue_item(OP_START, TIME_MAX - 1);
    queue_item(OP_TICK, TIME_MAX);
    queue_item(OP_TICK, TIME_MAX);
    queue_item(OP_TICK, TIME_MAX);
    queue_item(OP_RELEASE, 5);
    queue_item(OP_TICK, 5);
    queue_item(OP_TICK, 6);
    queue_item(OP_TICK, 7);
    wait_drained();

    // Exact landings: decay onto sustain and release onto 0 stay one more tick.
    cfg_write(CFG_SUSTAIN, LEVEL_ONE >> 1);
    cfg_write(CFG_ATTACK, LEVEL_ONE >> 1);
    cfg_write(CFG_DECAY, LEVEL_ONE >> 2);
    cfg_write(CFG_RELEASE, LEVEL_ONE >> 2);
    settings_used++;
    queue_item(OP_START, 1);
    for (int t = 2; t <= 7; t++)
      queue_item(OP_TICK, TIME_BITS'(t));
    queue_item(OP_RELEASE, 8);
    for (int t = 9; t <= 12; t++)
      queue_item(OP_TICK, TIME_BITS'(t));
    wait_drained();

    // Random bursts: slow sender, then slow receiver, then no idling with
    // one long receiver hold-off so the block backs up into its input.
    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 19 : (mode == 1) ? 78 : 0;
      recv_idle_pct = (mode == 0) ? 78 : (mode == 1) ? 19 : 0;
      for (int b = 0; b < BURSTS_PER_MODE; b++) begin
        shuffle_settings();
        if (mode == 2 && b == 0) begin
          @(negedge clk);
          hold_cycles = HOLD_LEN;
        end
        fill_burst(BURST_ITEMS);
        wait_drained();
      end
    end

    errors += levels_due.size();
    $display("Run covered %0d envelope events and %0d checked levels", items_queued,
             levels_checked);
    $display("across %0d register settings, three idle mixes and one long hold-off.",
             settings_used);
    if (errors == 0)
      $display("[adsr_envelope_generator] OK");
    else
      $display("[adsr_envelope_generator] ERROR");
    $finish;
  end

endmodule

`default_nettype wire
